[src/deqr_pkg.sv]
// Shared constants, request and status codes for the ring deque.
package deqr_pkg;

   localparam int DEF_CAPACITY   = 16;
   localparam int DEF_DATA_WIDTH = 32;

   localparam int REQ_W  = 3;
   localparam int WORD_W = 32;
   localparam int OCC_W  = 5;
   localparam int STAT_W = 2;

   localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd0;
   localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd1;
   localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd2;
   localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd3;
   localparam logic [REQ_W-1:0] REQ_PEEK       = 3'd4;

   localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
   localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_READ = 2'b10
   } state_type;

endpackage

[src/deqr_if.sv]
// Request and response channel interfaces of the ring deque.
interface deqr_req_if import deqr_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [REQ_W-1:0]  req_type;
   logic [WORD_W-1:0] data_in;

   modport source (output valid, output req_type, output data_in, input ready);
   modport sink   (input valid, input req_type, input data_in, output ready);
endinterface

interface deqr_rsp_if import deqr_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] front_word;
   logic [WORD_W-1:0] back_word;
   logic [OCC_W-1:0]  occupancy;
   logic              is_empty;
   logic              is_full;
   logic [STAT_W-1:0] status;

   modport source (output valid, output front_word, output back_word, output occupancy,
                   output is_empty, output is_full, output status, input ready);
   modport sink   (input valid, input front_word, input back_word, input occupancy,
                   input is_empty, input is_full, input status, output ready);
endinterface

[src/double_ended_queue_ring.sv]
// Double-ended queue over a ring store of CAPACITY words, one response per request.
//
// Each request transaction pushes at the front or back, pops from the front or back,
// or peeks, and returns one response with the front and back words, the occupancy and
// the empty, full and status flags after the operation. Pushes, peeks, rejected
// requests and pops that leave the queue empty are answered from ST_IDLE; any other
// pop passes through ST_READ, as the new end word comes from a registered read of the
// ring store. The front and back words are cached in registers beside the store.
// A response waits in its output register while the next request is held off until
// that register is taken or freed in the same cycle. No clearing pass after reset.
module double_ended_queue_ring import deqr_pkg::*; #(
   parameter int CAPACITY   = DEF_CAPACITY,
   parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
   input  logic         clock,
   input  logic         reset,
   deqr_req_if.sink     req_ch,
   deqr_rsp_if.source   rsp_ch
);

   localparam int PTR_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);

   logic [DATA_WIDTH-1:0] ring_mem [CAPACITY];

   state_type             state_ff, state_in;
   logic [PTR_W-1:0]      head_ff, head_in;
   logic [PTR_W-1:0]      tail_ff, tail_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [DATA_WIDTH-1:0] front_ff, front_in;
   logic [DATA_WIDTH-1:0] back_ff, back_in;
   logic [STAT_W-1:0]     status_ff, status_in;
   logic                  read_back_ff, read_back_in;
   logic [DATA_WIDTH-1:0] rd_data_ff;

   logic                  wr_en;
   logic [PTR_W-1:0]      wr_addr;
   logic [PTR_W-1:0]      rd_addr;
   logic [DATA_WIDTH-1:0] word;
   logic                  accept;
   logic                  empty;
   logic                  full;

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(CAPACITY - 1)) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
      return (p == '0) ? PTR_W'(CAPACITY - 1) : p - 1'b1;
   endfunction

   assign empty  = (count_ff == '0);
   assign full   = (count_ff == CNT_W'(CAPACITY));
   assign word   = DATA_WIDTH'(64'(req_ch.data_in));
   assign req_ch.ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ch.ready);
   assign accept = req_ch.valid && req_ch.ready;

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      front_in     = front_ff;
      back_in      = back_ff;
      status_in    = status_ff;
      read_back_in = read_back_ff;
      wr_en        = 1'b0;
      wr_addr      = head_ff;
      rd_addr      = head_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               status_in    = STAT_OK;
               rsp_valid_in = 1'b1;
               case (req_ch.req_type)
                  REQ_PUSH_FRONT: begin
                     if (full) begin
                        status_in = STAT_FULL;
                     end else begin
                        head_in  = ptr_dec(head_ff);
                        wr_en    = 1'b1;
                        wr_addr  = head_in;
                        front_in = word;
                        if (empty) begin
                           back_in = word;
                        end
                        count_in = count_ff + 1'b1;
                     end
                  end
                  REQ_PUSH_BACK: begin
                     if (full) begin
                        status_in = STAT_FULL;
                     end else begin
                        tail_in = ptr_inc(tail_ff);
                        wr_en   = 1'b1;
                        wr_addr = tail_in;
                        back_in = word;
                        if (empty) begin
                           front_in = word;
                        end
                        count_in = count_ff + 1'b1;
                     end
                  end
                  REQ_POP_FRONT: begin
                     if (empty) begin
                        status_in = STAT_EMPTY;
                     end else begin
                        head_in  = ptr_inc(head_ff);
                        rd_addr  = head_in;
                        count_in = count_ff - 1'b1;
                        if (count_ff != CNT_W'(1)) begin
                           read_back_in = 1'b0;
                           rsp_valid_in = 1'b0;
                           state_in     = ST_READ;
                        end
                     end
                  end
                  REQ_POP_BACK: begin
                     if (empty) begin
                        status_in = STAT_EMPTY;
                     end else begin
                        tail_in  = ptr_dec(tail_ff);
                        rd_addr  = tail_in;
                        count_in = count_ff - 1'b1;
                        if (count_ff != CNT_W'(1)) begin
                           read_back_in = 1'b1;
                           rsp_valid_in = 1'b0;
                           state_in     = ST_READ;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_READ: begin
            if (read_back_ff) begin
               back_in = rd_data_ff;
            end else begin
               front_in = rd_data_ff;
            end
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ring_mem[wr_addr] <= word;
      end
      rd_data_ff <= ring_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= PTR_W'(CAPACITY - 1);
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      front_ff     <= front_in;
      back_ff      <= back_in;
      status_ff    <= status_in;
      read_back_ff <= read_back_in;
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.front_word = empty ? '0 : WORD_W'(64'(front_ff));
   assign rsp_ch.back_word  = empty ? '0 : WORD_W'(64'(back_ff));
   assign rsp_ch.occupancy  = OCC_W'(count_ff);
   assign rsp_ch.is_empty   = empty;
   assign rsp_ch.is_full    = full;
   assign rsp_ch.status     = status_ff;

endmodule

[src/deqr_chk.sv]
// Port-level checks of the ring deque and their binding to the top level.
module deqr_chk import deqr_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [WORD_W-1:0] front_word,
   input logic [WORD_W-1:0] back_word,
   input logic [OCC_W-1:0]  occupancy,
   input logic              is_empty,
   input logic              is_full,
   input logic [STAT_W-1:0] status
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(front_word) && $stable(back_word)
         && $stable(occupancy) && $stable(status))
      else $error("response changed while stalled");

   a_slot_free: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |-> !rsp_valid || rsp_ready)
      else $error("request taken while response slot occupied");

   a_answer: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid || !req_ready)
      else $error("request neither answered nor blocking");

   a_reject: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (status != STAT_FULL || is_full) && (status != STAT_EMPTY || is_empty))
      else $error("rejection status disagrees with flags");

endmodule

bind double_ended_queue_ring deqr_chk u_deqr_chk (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_ch.valid),
   .req_ready  (req_ch.ready),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .front_word (rsp_ch.front_word),
   .back_word  (rsp_ch.back_word),
   .occupancy  (rsp_ch.occupancy),
   .is_empty   (rsp_ch.is_empty),
   .is_full    (rsp_ch.is_full),
   .status     (rsp_ch.status)
);
